// File: rtl/core/spts_pkg.sv
// ----------------------------------------------------------------------------
// spts_pkg: shared types and constants of the sparse polynomial term store
// Table size, derived widths, op and status codes and state machine types.
// ----------------------------------------------------------------------------
package spts_pkg;

  localparam int MAX_TERMS = 16;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int COEF_W    = 32;
  localparam int EXPO_W    = 8;
  localparam int TCNT_W    = 5;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_EVAL  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CLOSE,
    S_OPEN,
    S_EVAL_FETCH,
    S_EVAL_WAIT,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    P_IDLE,
    P_MUL,
    P_SQR
  } pow_state_t;

endpackage

// File: rtl/core/spts_pow.sv
// ----------------------------------------------------------------------------
// spts_pow: term value unit
// Computes coef * x^expo modulo 2^32 by square and multiply on one shared
// 32 by 32 multiplier, one multiplication per cycle.
// ----------------------------------------------------------------------------
module spts_pow
  import spts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [COEF_W-1:0] coef,
  input  logic [EXPO_W-1:0] expo,
  input  logic [COEF_W-1:0] point,
  output logic              done,
  output logic [COEF_W-1:0] result
);

  pow_state_t        state;
  pow_state_t        state_next;
  logic [COEF_W-1:0] r;
  logic [COEF_W-1:0] p;
  logic [EXPO_W-1:0] e;
  logic              sel_r;
  logic [COEF_W-1:0] mul_a;
  logic [COEF_W-1:0] prod;

  always_comb begin
    state_next = state;
    unique case (state)
      P_IDLE: begin
        if (start) state_next = P_MUL;
      end
      P_MUL: begin
        if (e == '0) state_next = P_IDLE;
        else if (e[0]) state_next = P_SQR;
      end
      P_SQR: begin
        state_next = P_MUL;
      end
      default: state_next = P_IDLE;
    endcase
  end

  always_comb begin
    done  = (state == P_MUL) && (e == '0);
    sel_r = (state == P_MUL) && e[0];
  end

  // low word only, so the wrap is free
  assign mul_a  = sel_r ? r : p;
  assign prod   = mul_a * p;
  assign result = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == P_IDLE) begin
      if (start) begin
        r <= coef;
        p <= point;
        e <= expo;
      end
    end else if (e != '0) begin
      if (sel_r) begin
        r <= prod;
      end else begin
        p <= prod;
        e <= e >> 1;
      end
    end
  end

endmodule

// File: rtl/core/sparse_polynomial_term_store.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_term_store: sorted sparse polynomial with evaluation
// Holds up to MAX_TERMS nonzero terms in descending exponent order; adds
// terms, clears the table and evaluates it modulo 2^32.
// ----------------------------------------------------------------------------
// One word in gives one word out, and the block takes a single word at a
// time. A clear, an unused op or a zero-coefficient add goes straight from
// idle to the done state. An add walks the table one entry per cycle to
// find its place and then, for a new or a cancelled term, moves the later
// entries one per cycle to open or close a gap; the walk and the move
// together cover the table once. Evaluation fetches each stored term in
// turn and runs it through a single shared multiplier by square and
// multiply. A finished result waits in the output register while the next
// word is taken.
module sparse_polynomial_term_store
  import spts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               op,
  input  logic signed [COEF_W-1:0] coefficient,
  input  logic [EXPO_W-1:0]        exponent,
  input  logic signed [COEF_W-1:0] eval_point,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     status,
  output logic signed [COEF_W-1:0] value,
  output logic [TCNT_W-1:0]        term_count
);

  // term table
  logic [COEF_W-1:0] coef_mem [MAX_TERMS];
  logic [EXPO_W-1:0] expo_mem [MAX_TERMS];

  seq_state_t        state;
  seq_state_t        state_next;

  logic [1:0]        op_q;
  logic [COEF_W-1:0] c_q;
  logic [EXPO_W-1:0] ex_q;
  logic [COEF_W-1:0] x_q;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  k;
  logic              res_status;
  logic [COEF_W-1:0] acc;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic [CNT_W-1:0]  k_inc;
  logic [CNT_W-1:0]  k_dec;
  logic [IDX_W-1:0]  rd_idx;
  logic [COEF_W-1:0] rd_coef;
  logic [EXPO_W-1:0] rd_expo;
  logic [COEF_W-1:0] sum;
  logic              pos_live;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [COEF_W-1:0] wr_coef;
  logic [EXPO_W-1:0] wr_expo;
  logic              pow_start;
  logic              pow_done;
  logic [COEF_W-1:0] pow_result;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign k_inc    = k + 1'b1;
  assign k_dec    = k - 1'b1;
  assign rd_coef  = coef_mem[rd_idx];
  assign rd_expo  = expo_mem[rd_idx];
  assign sum      = rd_coef + c_q;
  assign pos_live = pos < cnt;

  spts_pow u_pow (
    .clk    (clk),
    .rst    (rst),
    .start  (pow_start),
    .coef   (rd_coef),
    .expo   (rd_expo),
    .point  (x_q),
    .done   (pow_done),
    .result (pow_result)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_ADD && coefficient != '0) state_next = S_SEARCH;
          else if (op == OP_EVAL) state_next = S_EVAL_FETCH;
          else state_next = S_DONE;
        end
      end
      S_SEARCH: begin
        if (pos_live && rd_expo > ex_q) state_next = S_SEARCH;
        else if (pos_live && rd_expo == ex_q) state_next = (sum != '0) ? S_DONE : S_CLOSE;
        else if (cnt == CNT_W'(MAX_TERMS)) state_next = S_DONE;
        else state_next = S_OPEN;
      end
      S_CLOSE: begin
        if (!(k_inc < cnt)) state_next = S_DONE;
      end
      S_OPEN: begin
        if (!(k > pos)) state_next = S_DONE;
      end
      S_EVAL_FETCH: begin
        state_next = (k < cnt) ? S_EVAL_WAIT : S_DONE;
      end
      S_EVAL_WAIT: begin
        if (pow_done) state_next = S_EVAL_FETCH;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = rst || (state != S_IDLE);
    load_out  = (state == S_DONE) && out_free;
    pow_start = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = pos[IDX_W-1:0];
    wr_coef   = sum;
    wr_expo   = ex_q;
    rd_idx    = pos[IDX_W-1:0];
    unique case (state)
      S_SEARCH: begin
        wr_en = pos_live && rd_expo == ex_q && sum != '0;
      end
      S_CLOSE: begin
        rd_idx  = k_inc[IDX_W-1:0];
        wr_idx  = k[IDX_W-1:0];
        wr_coef = rd_coef;
        wr_expo = rd_expo;
        wr_en   = k_inc < cnt;
      end
      S_OPEN: begin
        rd_idx = k_dec[IDX_W-1:0];
        wr_en  = 1'b1;
        if (k > pos) begin
          wr_idx  = k[IDX_W-1:0];
          wr_coef = rd_coef;
          wr_expo = rd_expo;
        end else begin
          wr_coef = c_q;
        end
      end
      S_EVAL_FETCH: begin
        rd_idx    = k[IDX_W-1:0];
        pow_start = k < cnt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      coef_mem[wr_idx] <= wr_coef;
      expo_mem[wr_idx] <= wr_expo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (accept && op == OP_CLEAR) cnt <= '0;
      else if (state == S_CLOSE && !(k_inc < cnt)) cnt <= cnt - 1'b1;
      else if (state == S_OPEN && !(k > pos)) cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op;
      c_q        <= coefficient;
      ex_q       <= exponent;
      x_q        <= eval_point;
      pos        <= '0;
      k          <= '0;
      acc        <= '0;
      res_status <= ST_DONE;
    end
    unique case (state)
      S_SEARCH: begin
        if (pos_live && rd_expo > ex_q) begin
          pos <= pos + 1'b1;
        end else if (pos_live && rd_expo == ex_q) begin
          k <= pos;
        end else if (cnt == CNT_W'(MAX_TERMS)) begin
          res_status <= ST_FULL;
        end else begin
          k <= cnt;
        end
      end
      S_CLOSE: begin
        if (k_inc < cnt) k <= k_inc;
      end
      S_OPEN: begin
        if (k > pos) k <= k_dec;
      end
      S_EVAL_WAIT: begin
        if (pow_done) begin
          acc <= acc + pow_result;
          k   <= k_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // output register, loaded only when the previous word has gone
  always_ff @(posedge clk) begin
    if (load_out) begin
      status     <= res_status;
      value      <= acc;
      term_count <= TCNT_W'(cnt);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_TERMS))
    else $error("term count beyond table size");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    load_out && res_status == ST_FULL |-> cnt == CNT_W'(MAX_TERMS) && op_q == OP_ADD)
    else $error("full status with room in the table");

  a_value_only_eval: assert property (@(posedge clk) disable iff (rst)
    load_out && acc != '0 |-> op_q == OP_EVAL)
    else $error("nonzero value for an op other than evaluate");

  a_pow_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    pow_done |-> state == S_EVAL_WAIT)
    else $error("term unit finished outside an evaluation wait");

endmodule

// File: tb/sparse_polynomial_term_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_term_store_tb: self-checking bench for the term store
// Drives add, evaluate, clear and unused-op words through the valid/stall
// handshake, keeps its own copy of the sorted term table to predict every
// result, and compares each result field by field in arrival order. Runs a
// directed opening and then random traffic under several idling patterns.
// ----------------------------------------------------------------------------
module sparse_polynomial_term_store_tb;
  import spts_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 2_000_000;
  localparam int         DRAIN_CYCLES = 400;
  localparam logic [31:0] COEF_MIN   = 32'h8000_0000;
  localparam logic [31:0] COEF_MAX   = 32'h7fff_ffff;

  typedef struct packed {
    logic [1:0]        op;
    logic [COEF_W-1:0] coefficient;
    logic [EXPO_W-1:0] exponent;
    logic [COEF_W-1:0] x;
  } word_t;

  typedef struct packed {
    logic              status;
    logic [COEF_W-1:0] value;
    logic [TCNT_W-1:0] cnt;
  } reply_t;

  typedef struct packed {
    logic [MAX_TERMS-1:0][COEF_W-1:0] coef;
    logic [MAX_TERMS-1:0][EXPO_W-1:0] expo;
    logic [TCNT_W-1:0]                cnt;
  } poly_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               op = '0;
  logic signed [COEF_W-1:0] coefficient = '0;
  logic [EXPO_W-1:0]        exponent = '0;
  logic signed [COEF_W-1:0] eval_point = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     status;
  logic signed [COEF_W-1:0] value;
  logic [TCNT_W-1:0]        term_count;

  sparse_polynomial_term_store uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .coefficient (coefficient),
    .exponent    (exponent),
    .eval_point  (eval_point),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .value       (value),
    .term_count  (term_count)
  );

  always #6 clk = ~clk;

  word_t  pending_words[$];
  reply_t expected_replies[$];
  poly_t  planned_poly = '0;  // table as the generator will have left it
  poly_t  poly_now = '0;      // table after the last accepted word
  logic   word_taken = 1'b0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     words_queued = 0;
  int     replies_checked = 0;
  int     errors = 0;
  int     cycles = 0;
  int     n_add = 0, n_dropped = 0, n_removed = 0, n_eval = 0, n_clear = 0;
  int     n_unused = 0, peak_terms = 0;

  // next table and the result for one word
  function automatic poly_t apply_word(input poly_t p, input word_t w, output reply_t r);
    int          pos;
    int          k;
    int          j;
    logic [31:0] sum;
    logic [31:0] acc;
    r = '0;
    case (w.op)
      OP_ADD: begin
        if (w.coefficient != 0) begin
          pos = 0;
          while (pos < p.cnt && p.expo[pos] > w.exponent) pos++;
          if (pos < p.cnt && p.expo[pos] == w.exponent) begin
            sum = p.coef[pos] + w.coefficient;
            if (sum != 0) begin
              p.coef[pos] = sum;
            end else begin
              // cancelled term, later entries close up
              for (k = pos; k + 1 < p.cnt; k++) begin
                p.coef[k] = p.coef[k+1];
                p.expo[k] = p.expo[k+1];
              end
              p.cnt = p.cnt - 1;
            end
          end else if (p.cnt >= MAX_TERMS) begin
            r.status = ST_FULL;
          end else begin
            for (k = p.cnt; k > pos; k--) begin
              p.coef[k] = p.coef[k-1];
              p.expo[k] = p.expo[k-1];
            end
            p.coef[pos] = w.coefficient;
            p.expo[pos] = w.exponent;
            p.cnt = p.cnt + 1;
          end
        end
      end
      OP_EVAL: begin
        sum = '0;
        for (k = 0; k < p.cnt; k++) begin
          acc = p.coef[k];
          for (j = 0; j < p.expo[k]; j++) acc = acc * w.x;
          sum = sum + acc;
        end
        r.value = sum;
      end
      OP_CLEAR: p.cnt = '0;
      default: ;
    endcase
    r.cnt = p.cnt;
    return p;
  endfunction

  function automatic word_t make_word(logic [1:0] o, logic [31:0] c, logic [7:0] e,
                                      logic [31:0] x);
    word_t w;
    w.op = o;
    w.coefficient = c;
    w.exponent = e;
    w.x = x;
    return w;
  endfunction

  task automatic queue_word(input word_t w);
    reply_t unused_reply;
    planned_poly = apply_word(planned_poly, w, unused_reply);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // mostly adds on a narrow exponent range so the table fills and terms cancel
  task automatic queue_random_word();
    word_t w;
    int    sel;
    int    i;
    sel = $urandom_range(99);
    w.op = OP_ADD;
    w.coefficient = $urandom;
    w.x = $urandom;
    if ($urandom_range(9) < 7) w.exponent = 8'($urandom_range(23));
    else w.exponent = 8'($urandom);
    if (sel < 50) begin
      if ($urandom_range(3) == 0) w.coefficient = $urandom_range(8) - 4;
    end else if (sel < 62 && planned_poly.cnt > 0) begin
      i = $urandom_range(planned_poly.cnt - 1);
      w.coefficient = -planned_poly.coef[i];
      w.exponent = planned_poly.expo[i];
    end else if (sel < 68 && planned_poly.cnt > 0) begin
      i = $urandom_range(planned_poly.cnt - 1);
      w.exponent = planned_poly.expo[i];
    end else if (sel < 71) begin
      w.coefficient = '0;
    end else if (sel < 92) begin
      w.op = OP_EVAL;
      i = $urandom_range(9);
      if (i < 4) w.x = $urandom_range(6) - 3;
      else if (i == 4) w.x = COEF_MIN;
      else if (i == 5) w.x = COEF_MAX;
    end else if (sel < 96) begin
      w.op = OP_CLEAR;
    end else begin
      w.op = OP_UNUSED;
    end
    queue_word(w);
  endtask

  task automatic wait_all_done();
    while (pending_words.size() != 0 || replies_checked != words_queued) @(posedge clk);
  endtask

  // driver: new word or idle at the falling edge, payload held while stalled
  always @(negedge clk) begin
    if (!rst && (!in_valid || word_taken) && pending_words.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      word_t w;
      w = pending_words.pop_front();
      in_valid <= 1'b1;
      op <= w.op;
      coefficient <= w.coefficient;
      exponent <= w.exponent;
      eval_point <= w.x;
    end else if (!in_valid || word_taken) begin
      in_valid <= 1'b0;
      op <= 2'($urandom);
      coefficient <= $urandom;
      exponent <= 8'($urandom);
      eval_point <= $urandom;
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // accepted words update the table copy and queue their expected result
  always @(posedge clk) begin : take_words
    word_t             w;
    reply_t            r;
    logic [TCNT_W-1:0] prev_cnt;
    word_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      w = {op, coefficient, exponent, eval_point};
      prev_cnt = poly_now.cnt;
      poly_now = apply_word(poly_now, w, r);
      expected_replies.push_back(r);
      case (w.op)
        OP_ADD: begin
          n_add++;
          if (r.status == ST_FULL) n_dropped++;
          if (r.cnt < prev_cnt) n_removed++;
        end
        OP_EVAL:  n_eval++;
        OP_CLEAR: n_clear++;
        default:  n_unused++;
      endcase
      if (r.cnt > peak_terms) peak_terms = r.cnt;
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result: status %0d value %0d term_count %0d",
                 $time, status, value, term_count);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status,
                   status);
          errors++;
        end
        if (value !== want.value) begin
          $display("%0t: value mismatch: expected %0d actual %0d", $time,
                   $signed(want.value), value);
          errors++;
        end
        if (term_count !== want.cnt) begin
          $display("%0t: term_count mismatch: expected %0d actual %0d", $time, want.cnt,
                   term_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_replies.size());
      $display("sparse_polynomial_term_store_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    int ph;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed opening, no idling
    queue_word(make_word(OP_EVAL, 32'd0, 8'd0, 32'd5));          // empty table
    queue_word(make_word(OP_UNUSED, $urandom, 8'($urandom), $urandom));
    queue_word(make_word(OP_CLEAR, 32'd0, 8'd0, 32'd0));
    queue_word(make_word(OP_ADD, 32'd0, 8'd7, 32'd0));           // zero coefficient
    queue_word(make_word(OP_ADD, COEF_MAX, 8'd255, 32'd0));
    queue_word(make_word(OP_ADD, COEF_MIN, 8'd0, 32'd0));
    queue_word(make_word(OP_ADD, 32'd1, 8'd255, 32'd0));         // sum wraps to min
    queue_word(make_word(OP_ADD, COEF_MIN, 8'd255, 32'd0));      // cancels
    queue_word(make_word(OP_EVAL, 32'd0, 8'd0, 32'hffff_ffff));
    // fill the table, the last add finds it full
    for (k = 0; k < MAX_TERMS; k++)
      queue_word(make_word(OP_ADD, 32'(k + 2), 8'(2 * k + 1), 32'd0));
    queue_word(make_word(OP_ADD, 32'd3, 8'd1, 32'd0));           // merge while full
    queue_word(make_word(OP_ADD, COEF_MIN, 8'd0, 32'd0));        // removal while full
    queue_word(make_word(OP_EVAL, 32'd0, 8'd0, COEF_MAX));
    queue_word(make_word(OP_EVAL, 32'd0, 8'd0, COEF_MIN));
    queue_word(make_word(OP_EVAL, 32'd0, 8'd0, 32'd0));
    queue_word(make_word(OP_CLEAR, 32'd0, 8'd0, 32'd0));
    wait_all_done();

    // random traffic; each phase drains fully before the next begins
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      for (k = 0; k < 375; k++) queue_random_word();
      wait_all_done();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words: %0d adds (%0d dropped on a full table, %0d removals),",
             words_queued, n_add, n_dropped, n_removed);
    $display("  %0d evaluations, %0d clears, %0d unused ops, peak of %0d terms, %0d errors",
             n_eval, n_clear, n_unused, peak_terms, errors);
    if (errors == 0) begin
      $display("sparse_polynomial_term_store_tb: PASS");
    end else begin
      $display("sparse_polynomial_term_store_tb: FAIL");
    end
    $finish;
  end

endmodule
